[sv/lsb_stego_embed_extract_macros.svh]
`ifndef LSB_STEGO_EMBED_EXTRACT_MACROS_SVH
`define LSB_STEGO_EMBED_EXTRACT_MACROS_SVH

// Checks that apply in the same cycle as their condition.
`define LSBSE_CHECK_NOW(lbl, cond_a, cond_c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |-> (cond_c)) \
		else $error("lsbse: same-cycle check failed");

// Checks that apply in the cycle after their condition.
`define LSBSE_CHECK_NEXT(lbl, cond_a, cond_c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |=> (cond_c)) \
		else $error("lsbse: next-cycle check failed");

`endif

[sv/lsbse_pkg.sv]
`timescale 1ns / 1ps

package lsbse_pkg;

	localparam int PIXEL_COUNT_BITS_DEF = 24;
	localparam int COUNT_W = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int TRIPLE_LEN = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_PIXELS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MESSAGE_CHARS = 2'd2;

	localparam logic MODE_EMBED = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_THIRD
	} phase_t;

	typedef struct packed {
		logic                mode;
		logic [COUNT_W-1:0]  image_pixels;
		logic [COUNT_W-1:0]  message_chars;
	} cfg_t;

	typedef struct packed {
		logic        start_of_image;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [7:0]  message_char;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [7:0]  char_out;
		logic        char_valid;
		logic        message_done;
		logic        capacity_error;
	} pixel_out_t;

endpackage

[sv/lsbse_in_stage.sv]
`timescale 1ns / 1ps

module lsbse_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  in_valid,
	input  lsbse_pkg::pixel_in_t  in_word,
	output logic                  valid_s1,
	output lsbse_pkg::pixel_in_t  word_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

[sv/lsbse_core.sv]
`timescale 1ns / 1ps

module lsbse_core #(
	parameter int PIXEL_COUNT_BITS = lsbse_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  lsbse_pkg::pixel_in_t   pix,
	input  lsbse_pkg::cfg_t        cfg,
	output lsbse_pkg::pixel_out_t  res
);

	localparam int CW = ((PIXEL_COUNT_BITS > lsbse_pkg::COUNT_W) ?
		PIXEL_COUNT_BITS : lsbse_pkg::COUNT_W) + 2;

	logic [PIXEL_COUNT_BITS-1:0]   pp_q, pp_c, pp_n;
	lsbse_pkg::phase_t             tp_q, tp_c, tp_n;
	logic [lsbse_pkg::COUNT_W-1:0] cp_q, cp_c, cp_n;
	logic [7:0]                    held_q, held_c, held_n;
	logic [7:0]                    asm_q, asm_c, asm_n;
	logic                          fin_q, fin_c, fin_n;

	logic                          embed;
	logic                          cap_err;
	logic                          room;
	logic                          active;
	logic [7:0]                    ch;
	logic [7:0]                    r, g, b;
	logic                          cv;

	assign pp_c   = pix.start_of_image ? '0 : pp_q;
	assign tp_c   = pix.start_of_image ? lsbse_pkg::PH_FIRST : tp_q;
	assign cp_c   = pix.start_of_image ? '0 : cp_q;
	assign held_c = pix.start_of_image ? '0 : held_q;
	assign asm_c  = pix.start_of_image ? '0 : asm_q;
	assign fin_c  = pix.start_of_image ? 1'b0 : fin_q;

	assign embed = (cfg.mode == lsbse_pkg::MODE_EMBED);
	assign cap_err = embed && (((CW'(cfg.message_chars) << 1) + CW'(cfg.message_chars)) >
		CW'(cfg.image_pixels));
	assign room = (CW'(pp_c) + CW'(lsbse_pkg::TRIPLE_LEN)) <= CW'(cfg.image_pixels);
	assign active = !fin_c && !cap_err && !(embed && (cp_c >= cfg.message_chars)) &&
		!((tp_c == lsbse_pkg::PH_FIRST) && !room);
	assign ch = (tp_c == lsbse_pkg::PH_FIRST) ? pix.message_char : held_c;
	assign pp_n = (pp_c != '1) ? pp_c + PIXEL_COUNT_BITS'(1) : pp_c;

	always_comb begin
		r = pix.red_in;
		g = pix.green_in;
		b = pix.blue_in;
		held_n = held_c;
		asm_n = asm_c;
		tp_n = tp_c;
		cp_n = cp_c;
		fin_n = fin_c;
		cv = 1'b0;
		if (active) begin
			if (embed) begin
				held_n = ch;
				case (tp_c)
					lsbse_pkg::PH_FIRST: begin
						r = {pix.red_in[7:1], ch[0]};
						g = {pix.green_in[7:1], ch[1]};
						b = {pix.blue_in[7:1], ch[2]};
					end
					lsbse_pkg::PH_SECOND: begin
						r = {pix.red_in[7:1], ch[3]};
						g = {pix.green_in[7:1], ch[4]};
						b = {pix.blue_in[7:1], ch[5]};
					end
					lsbse_pkg::PH_THIRD: begin
						r = {pix.red_in[7:1], ch[6]};
						g = {pix.green_in[7:1], ch[7]};
					end
					default: begin
					end
				endcase
			end else begin
				case (tp_c)
					lsbse_pkg::PH_FIRST: begin
						asm_n = {5'b0, pix.blue_in[0], pix.green_in[0], pix.red_in[0]};
					end
					lsbse_pkg::PH_SECOND: begin
						asm_n = asm_c | {2'b0, pix.blue_in[0], pix.green_in[0],
							pix.red_in[0], 3'b0};
					end
					lsbse_pkg::PH_THIRD: begin
						asm_n = asm_c | {pix.green_in[0], pix.red_in[0], 6'b0};
						cv = 1'b1;
					end
					default: begin
					end
				endcase
			end
			case (tp_c)
				lsbse_pkg::PH_FIRST: begin
					tp_n = lsbse_pkg::PH_SECOND;
				end
				lsbse_pkg::PH_SECOND: begin
					tp_n = lsbse_pkg::PH_THIRD;
				end
				lsbse_pkg::PH_THIRD: begin
					tp_n = lsbse_pkg::PH_FIRST;
					cp_n = (cp_c != '1) ? cp_c + lsbse_pkg::COUNT_W'(1) : cp_c;
					if (embed) begin
						fin_n = (cp_n >= cfg.message_chars);
					end else begin
						fin_n = (asm_n == 8'd0);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res.red_out = r;
	assign res.green_out = g;
	assign res.blue_out = b;
	assign res.char_out = cv ? asm_n : 8'd0;
	assign res.char_valid = cv;
	assign res.message_done = fin_n;
	assign res.capacity_error = cap_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q <= '0;
			tp_q <= lsbse_pkg::PH_FIRST;
			cp_q <= '0;
			held_q <= '0;
			asm_q <= '0;
			fin_q <= 1'b0;
		end else if (adv) begin
			pp_q <= pp_n;
			tp_q <= tp_n;
			cp_q <= cp_n;
			held_q <= held_n;
			asm_q <= asm_n;
			fin_q <= fin_n;
		end
	end

endmodule

[sv/lsbse_out_stage.sv]
`timescale 1ns / 1ps

module lsbse_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic                   valid_s1,
	input  lsbse_pkg::pixel_out_t  res,
	output logic                   out_valid,
	output lsbse_pkg::pixel_out_t  out_word
);

	logic                  valid_s2;
	lsbse_pkg::pixel_out_t word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && valid_s1) begin
			word_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_word = word_s2;

endmodule

[sv/lsb_stego_embed_extract.sv]
// Pixel stream steganography unit. Pixels enter on the in channel (in_valid,
// in_stall, in_word) in image order and leave, one result word per pixel, on
// the out channel (out_valid, out_stall, out_word). A word is taken at a rising
// edge with valid high and stall low. Mode 0 hides message_char bits in the
// channel LSBs, three pixels per character; mode 1 passes pixels unchanged and
// presents each recovered character with char_valid on the third pixel.
// The cfg port (cfg_write, cfg_index, cfg_data) sets mode, image size and
// message length; write it only while no pixel is in flight.
// A pixel in the input register passes the combinational state update and the
// result register captures it for out_word. Throughput: one pixel per cycle
// while the receiver does not stall, set by the two registers with the state
// update between them. If the receiver stalls, the result register holds its
// word and the input register takes one more pixel only if empty; in_stall is
// then raised until the result is taken. Reset clears both valid flags, all
// counters and the configuration, which reads as embed mode with an empty image.
`timescale 1ns / 1ps

`include "lsb_stego_embed_extract_macros.svh"

module lsb_stego_embed_extract #(
	parameter int PIXEL_COUNT_BITS = lsbse_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  lsbse_pkg::pixel_in_t                 in_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output lsbse_pkg::pixel_out_t                out_word,
	input  logic                                 cfg_write,
	input  logic [lsbse_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lsbse_pkg::COUNT_W-1:0]        cfg_data
);

	lsbse_pkg::cfg_t       cfg_q;
	logic                  valid_s1;
	lsbse_pkg::pixel_in_t  word_s1;
	lsbse_pkg::pixel_out_t res;
	logic                  adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				lsbse_pkg::CFG_MODE: cfg_q.mode <= cfg_data[0];
				lsbse_pkg::CFG_IMAGE_PIXELS: cfg_q.image_pixels <= cfg_data;
				lsbse_pkg::CFG_MESSAGE_CHARS: cfg_q.message_chars <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv_out = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv_out;

	lsbse_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (!in_stall),
		.in_valid (in_valid),
		.in_word  (in_word),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	lsbse_core #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (valid_s1 && adv_out),
		.pix    (word_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	lsbse_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv_out),
		.valid_s1  (valid_s1),
		.res       (res),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	`LSBSE_CHECK_NOW(a_char_not_with_cap_err, out_valid && out_word.char_valid, !out_word.capacity_error)
	`LSBSE_CHECK_NOW(a_char_zero_when_idle, out_valid && !out_word.char_valid, out_word.char_out == 8'd0)
	`LSBSE_CHECK_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall && valid_s1)
	`LSBSE_CHECK_NEXT(a_held_input_flows, valid_s1 && !out_stall, out_valid)

endmodule
